[sv/ewrp_pkg.sv]
// Shared constants and functions for the ECG wavelet R-peak detector.
package ewrp_pkg;

    localparam int TAPS      = 32;
    localparam int TAP_W     = $clog2(TAPS);
    localparam int HISTORY   = 8;
    localparam int HIST_W    = $clog2(HISTORY);
    localparam int SCALE_SH  = 8;             // divide by 256
    localparam int SCALE_DIV = 1 << SCALE_SH;
    localparam int DIGIT_W   = 4;             // coefficient digit per cycle
    localparam int DIGITS    = 16 / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);
    localparam int ACC_W     = 48;

    // threshold divider: magnitude of the dividend, one quotient bit per cycle
    localparam int DIV_W     = 40;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int TRAIN_MUL = 4;
    localparam int TRAIN_DEN = 10;
    localparam int SCAN_MUL  = 55;
    localparam int SCAN_DEN  = 100;

    localparam logic [2:0] PH_FILL  = 3'd0;
    localparam logic [2:0] PH_TRAIN = 3'd1;
    localparam logic [2:0] PH_SEARCH = 3'd2;
    localparam logic [2:0] PH_DOWN  = 3'd3;
    localparam logic [2:0] PH_UP    = 3'd4;

    localparam logic [1:0] REG_SKIP  = 2'd0;
    localparam logic [1:0] REG_TRAIN = 2'd1;
    localparam logic [1:0] REG_IMAX  = 2'd2;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sh7FFFFFFF))
            r = 32'sh7FFFFFFF;
        else if (v < -ACC_W'(64'sh80000000))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[sv/ecg_wavelet_r_peak_detector.sv]
// Top level of the ECG wavelet R-peak detector.
// Usage:
//  - s_axis_*: one request per item. tuser = action; tdata = sample 15:0,
//    coef_index 20:16, coef_value 36:21, padded to 40 bits.
//  - m_axis_*: one result per item, tdata = wavelet_out 31:0, peak_found 32,
//    peak_value 64:33, threshold_now 96:65, phase 99:97, padded to 104 bits.
//  - cfg_*: register writes (0 skip_samples, 1 training_outputs,
//    2 initial_max), only while no request is in flight.
// Path of each item, from the accepted request to the valid result:
//  - coefficient load or sample while filling: straight to the output state.
//  - convolving sample: 32 taps through the digit-serial multiplier
//    (one load step plus four 4-bit coefficient digits per tap), then the
//    post state and the output state.
//  - end of training: adds the bit-serial threshold divider.
//  - threshold rebuild: adds the history scan and then the divider.
// One item at a time: the next request is accepted only after the result
// is handed off. A stalled receiver holds the result and the block accepts
// nothing until it is taken.
// Reset clears all control state, the sample ring and coefficient store
// (through valid bits), phase back to filling.
module ecg_wavelet_r_peak_detector
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // sample, coef_index, coef_value
    input  logic [0:0]   s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // wavelet_out, peak_found, peak_value,
                                        // threshold_now, phase
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_POST = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_WAIT = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;

    logic [2:0] st_reg, st_next;

    logic signed [15:0] ring_mem [ewrp_pkg::TAPS];
    logic signed [15:0] coef_mem [ewrp_pkg::TAPS];
    logic [ewrp_pkg::TAPS-1:0] ring_vld_reg, coef_vld_reg;
    logic signed [31:0] hist_mem [ewrp_pkg::HISTORY];

    logic [15:0] skip_reg, trn_reg;
    logic signed [31:0] imax_reg;
    logic [ewrp_pkg::TAP_W-1:0] wpos_reg;
    logic [ewrp_pkg::HIST_W-1:0] hpos_reg;
    logic hfull_reg;
    logic [2:0] ph_reg;
    logic [15:0] skc_reg, tcnt_reg;
    logic signed [31:0] rmax_reg, thr_reg, last_reg;
    logic found_reg;

    logic [ewrp_pkg::TAP_W:0] tap_reg;
    logic [ewrp_pkg::TAP_W-1:0] ridx;
    logic signed [15:0] rd_s, rd_c;
    logic mac_load, mac_start, mac_busy;
    logic signed [ewrp_pkg::ACC_W-1:0] mac_acc, scaled;
    logic signed [63:0] sum_reg, hi_reg, lo_reg;
    logic [ewrp_pkg::HIST_W:0] scnt_reg;
    logic [ewrp_pkg::HIST_W-1:0] sidx;
    logic signed [63:0] hv, aux;
    logic signed [31:0] conv_val;

    // threshold divider
    logic [ewrp_pkg::DIV_W-1:0] div_num_reg;
    logic [6:0] div_rem_reg;
    logic div_neg_reg, div_scan_reg;
    logic [ewrp_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [7:0] div_sh, div_den;
    logic signed [63:0] div_src, div_mag;
    logic signed [ewrp_pkg::ACC_W-1:0] div_res;
    logic [15:0] tcnt_inc;
    logic trn_done;
    logic signed [31:0] new_max;

    logic in_acc;
    logic signed [15:0] in_smp, in_cv;
    logic [4:0] in_ci;

    assign in_smp = s_axis_tdata[15:0];
    assign in_ci  = s_axis_tdata[20:16];
    assign in_cv  = s_axis_tdata[36:21];
    assign s_axis_tready = (st_reg == ST_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    assign ridx = wpos_reg + tap_reg[ewrp_pkg::TAP_W-1:0];
    assign rd_s = ring_vld_reg[ridx] ? ring_mem[ridx] : 16'sd0;
    assign rd_c = coef_vld_reg[tap_reg[ewrp_pkg::TAP_W-1:0]]
                  ? coef_mem[tap_reg[ewrp_pkg::TAP_W-1:0]] : 16'sd0;
    assign mac_start = in_acc;
    assign mac_load  = (st_reg == ST_MAC) && !mac_busy && (tap_reg != '1)
                       && !tap_reg[ewrp_pkg::TAP_W];

    ewrp_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .load  (mac_load),
        .smp   (rd_s),
        .coef  (rd_c),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    // truncate toward zero on divide by 2^SCALE_SH
    assign scaled = (mac_acc < 0)
        ? -((-mac_acc) >>> ewrp_pkg::SCALE_SH) : (mac_acc >>> ewrp_pkg::SCALE_SH);
    assign conv_val = ewrp_pkg::sat32(scaled);

    assign sidx = hpos_reg + scnt_reg[ewrp_pkg::HIST_W-1:0];
    assign hv   = 64'(hist_mem[sidx]);
    assign aux  = (sum_reg - lo_reg - hi_reg) / 4;

    // training end: count after this output and the updated maximum
    assign tcnt_inc = (tcnt_reg != 16'hFFFF) ? tcnt_reg + 16'd1 : tcnt_reg;
    assign trn_done = (ph_reg == ewrp_pkg::PH_TRAIN) && (tcnt_inc >= trn_reg);
    assign new_max  = (conv_val >= rmax_reg) ? conv_val : rmax_reg;

    // dividend: max*4 (over 10) at training end, aux*55 (over 100) on rebuild;
    // divide the magnitude, restore the sign -> truncation toward zero
    assign div_src = (st_reg == ST_SCAN)
        ? aux * 64'(ewrp_pkg::SCAN_MUL)
        : 64'(new_max) * 64'(ewrp_pkg::TRAIN_MUL);
    assign div_mag = div_src[63] ? -div_src : div_src;
    assign div_sh  = {div_rem_reg, div_num_reg[ewrp_pkg::DIV_W-1]};
    assign div_den = div_scan_reg ? 8'(ewrp_pkg::SCAN_DEN) : 8'(ewrp_pkg::TRAIN_DEN);
    assign div_res = div_neg_reg
        ? -$signed({{(ewrp_pkg::ACC_W-ewrp_pkg::DIV_W){1'b0}}, div_num_reg})
        : $signed({{(ewrp_pkg::ACC_W-ewrp_pkg::DIV_W){1'b0}}, div_num_reg});

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    if (s_axis_tuser[0] == ewrp_pkg::ACT_COEF || ph_reg == ewrp_pkg::PH_FILL
                        || ph_reg > ewrp_pkg::PH_UP)
                        st_next = ST_OUT;
                    else
                        st_next = ST_MAC;
                end
            ST_MAC:
                if (tap_reg[ewrp_pkg::TAP_W] && !mac_busy)
                    st_next = ST_POST;
            ST_POST:
                if (ph_reg == ewrp_pkg::PH_DOWN && conv_val < thr_reg && hfull_reg)
                    st_next = ST_SCAN;
                else if (trn_done)
                    st_next = ST_DIV;
                else
                    st_next = ST_OUT;
            ST_SCAN:
                if (scnt_reg[ewrp_pkg::HIST_W])
                    st_next = ST_DIV;
            ST_DIV:
                if (div_cnt_reg == ewrp_pkg::DIV_CNT_W'(ewrp_pkg::DIV_W))
                    st_next = ST_OUT;
            ST_OUT:
                st_next = ST_WAIT;
            ST_WAIT:
                if (m_axis_tready)
                    st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ring_vld_reg <= '0;
            coef_vld_reg <= '0;
            skip_reg <= '0;
            trn_reg <= 16'd256;
            imax_reg <= '0;
            wpos_reg <= '0;
            hpos_reg <= '0;
            hfull_reg <= 1'b0;
            ph_reg <= ewrp_pkg::PH_FILL;
            skc_reg <= '0;
            tcnt_reg <= '0;
            rmax_reg <= '0;
            thr_reg <= '0;
            last_reg <= '0;
            found_reg <= 1'b0;
            tap_reg <= '0;
            scnt_reg <= '0;
            sum_reg <= '0;
            hi_reg <= '0;
            lo_reg <= '0;
            div_num_reg <= '0;
            div_rem_reg <= '0;
            div_neg_reg <= 1'b0;
            div_scan_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ewrp_pkg::REG_SKIP:  skip_reg <= cfg_data[15:0];
                    ewrp_pkg::REG_TRAIN: trn_reg <= cfg_data[15:0];
                    ewrp_pkg::REG_IMAX:
                    begin
                        imax_reg <= cfg_data;
                        if (ph_reg == ewrp_pkg::PH_FILL)
                            rmax_reg <= cfg_data;
                    end
                    default: ;
                endcase
            end
            case (st_reg)
                ST_IDLE:
                    if (in_acc)
                    begin
                        found_reg <= 1'b0;
                        tap_reg <= '0;
                        if (s_axis_tuser[0] == ewrp_pkg::ACT_COEF)
                            coef_vld_reg[in_ci] <= 1'b1;
                        else if (ph_reg == ewrp_pkg::PH_FILL)
                        begin
                            if (skc_reg < skip_reg)
                                skc_reg <= skc_reg + 1'b1;
                            else
                            begin
                                ring_vld_reg[wpos_reg] <= 1'b1;
                                wpos_reg <= wpos_reg + 1'b1;
                                if (wpos_reg == '1)
                                    ph_reg <= ewrp_pkg::PH_TRAIN;
                            end
                        end
                        else if (ph_reg <= ewrp_pkg::PH_UP)
                        begin
                            ring_vld_reg[wpos_reg] <= 1'b1;
                            wpos_reg <= wpos_reg + 1'b1;
                        end
                    end
                ST_MAC:
                    if (mac_load)
                        tap_reg <= tap_reg + 1'b1;
                    else if (!mac_busy && tap_reg == '1)
                        tap_reg <= tap_reg + 1'b1;
                ST_POST:
                begin
                    last_reg <= conv_val;
                    sum_reg <= '0;
                    hi_reg <= 64'(imax_reg);
                    lo_reg <= 64'(hist_mem[hpos_reg]);
                    scnt_reg <= '0;
                    if (trn_done)
                    begin
                        div_num_reg <= div_mag[ewrp_pkg::DIV_W-1:0];
                        div_neg_reg <= div_src[63];
                        div_scan_reg <= 1'b0;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                    end
                    case (ph_reg)
                        ewrp_pkg::PH_TRAIN:
                        begin
                            if (tcnt_reg != 16'hFFFF)
                                tcnt_reg <= tcnt_inc;
                            if (conv_val >= rmax_reg)
                                rmax_reg <= conv_val;
                            if (trn_done)
                                ph_reg <= ewrp_pkg::PH_SEARCH;
                        end
                        ewrp_pkg::PH_SEARCH:
                            if (conv_val >= rmax_reg)
                                rmax_reg <= conv_val;
                            else
                            begin
                                found_reg <= 1'b1;
                                hpos_reg <= hpos_reg + 1'b1;
                                if (hpos_reg == '1)
                                    hfull_reg <= 1'b1;
                                ph_reg <= ewrp_pkg::PH_DOWN;
                            end
                        ewrp_pkg::PH_DOWN:
                            if (conv_val < thr_reg)
                                ph_reg <= ewrp_pkg::PH_UP;
                        ewrp_pkg::PH_UP:
                            if (conv_val > thr_reg)
                            begin
                                rmax_reg <= conv_val;
                                ph_reg <= ewrp_pkg::PH_SEARCH;
                            end
                        default: ;
                    endcase
                end
                ST_SCAN:
                    if (!scnt_reg[ewrp_pkg::HIST_W])
                    begin
                        sum_reg <= sum_reg + hv;
                        if (hv >= hi_reg) hi_reg <= hv;
                        if (hv <= lo_reg) lo_reg <= hv;
                        scnt_reg <= scnt_reg + 1'b1;
                    end
                    else
                    begin
                        div_num_reg <= div_mag[ewrp_pkg::DIV_W-1:0];
                        div_neg_reg <= div_src[63];
                        div_scan_reg <= 1'b1;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                    end
                ST_DIV:
                    // restoring division, one quotient bit per cycle
                    if (div_cnt_reg != ewrp_pkg::DIV_CNT_W'(ewrp_pkg::DIV_W))
                    begin
                        if (div_sh >= div_den)
                        begin
                            div_rem_reg <= 7'(div_sh - div_den);
                            div_num_reg <= {div_num_reg[ewrp_pkg::DIV_W-2:0], 1'b1};
                        end
                        else
                        begin
                            div_rem_reg <= div_sh[6:0];
                            div_num_reg <= {div_num_reg[ewrp_pkg::DIV_W-2:0], 1'b0};
                        end
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                    else
                        thr_reg <= ewrp_pkg::sat32(div_res);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (s_axis_tuser[0] == ewrp_pkg::ACT_COEF)
                coef_mem[in_ci] <= in_cv;
            else if ((ph_reg == ewrp_pkg::PH_FILL && skc_reg >= skip_reg)
                     || (ph_reg != ewrp_pkg::PH_FILL && ph_reg <= ewrp_pkg::PH_UP))
                ring_mem[wpos_reg] <= in_smp;
        end
        if (st_reg == ST_POST && ph_reg == ewrp_pkg::PH_SEARCH && conv_val < rmax_reg)
            hist_mem[hpos_reg] <= rmax_reg;
    end

    assign m_axis_tvalid = (st_reg == ST_WAIT);
    assign m_axis_tdata = {4'd0, ph_reg, thr_reg, rmax_reg, found_reg, last_reg};

endmodule

[sv/ewrp_mac.sv]
// Digit-serial multiply-accumulate: one 16x4 partial product per cycle while busy.
module ewrp_mac
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            load,
    input  logic signed [15:0]              smp,
    input  logic signed [15:0]              coef,
    output logic                            busy,
    output logic signed [ewrp_pkg::ACC_W-1:0] acc
);

    logic [15:0]                          shift_reg, shift_next;
    logic [ewrp_pkg::DIG_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                                 busy_reg, busy_next;
    logic signed [ewrp_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ewrp_pkg::ACC_W-1:0]    smp_reg, smp_next;
    logic signed [ewrp_pkg::ACC_W-1:0]    part;

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        acc_next   = acc_reg;
        smp_next   = smp_reg;
        // top digit of the coefficient is a signed digit
        if (cnt_reg == ewrp_pkg::DIG_CNT_W'(ewrp_pkg::DIGITS - 1))
            part = smp_reg * $signed(shift_reg[3:0]);
        else
            part = smp_reg * $signed({1'b0, shift_reg[3:0]});
        if (start)
            acc_next = '0;
        if (load)
        begin
            shift_next = coef;
            smp_next   = ewrp_pkg::ACC_W'(smp);
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next   = acc_reg + part;
            shift_next = shift_reg >> ewrp_pkg::DIGIT_W;
            smp_next   = smp_reg <<< ewrp_pkg::DIGIT_W;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == ewrp_pkg::DIG_CNT_W'(ewrp_pkg::DIGITS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        acc_reg   <= acc_next;
        smp_reg   <= smp_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

[sv/ewrp_checker.sv]
// Port-level checks for the R-peak detector, bound to the top level.
module ewrp_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);

    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[99:97] <= 3'd4) else $error("bad phase");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");

endmodule

bind ecg_wavelet_r_peak_detector ewrp_checker u_ewrp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
